[rtl/tmaf_pkg.sv]
// shared types and constants of the thermometer measure and average controller
package tmaf_pkg;

  localparam int RAW_W       = 16;
  localparam int PHASE_W     = 2;
  localparam int AVG_W       = 18;
  localparam int SAMPLES_DEF = 8;

  // 273.15 K expressed in hundredths of a degree
  localparam int OFFSET_CENTI = 27315;

  typedef enum logic [PHASE_W-1:0] {
    ST_WAITING   = 2'd0,
    ST_MEASURING = 2'd1,
    ST_DISPLAY   = 2'd2
  } state_t;

endpackage

[rtl/tmaf_if.sv]
// valid/ready channel interfaces for tick items and result items
interface tmaf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        button_pressed;
  logic                        sample_valid;
  logic [tmaf_pkg::RAW_W-1:0]  raw_temp;

  modport source (output valid, output button_pressed, output sample_valid,
                  output raw_temp, input ready);
  modport sink   (input valid, input button_pressed, input sample_valid,
                  input raw_temp, output ready);
  modport monitor (input valid, input ready, input button_pressed,
                   input sample_valid, input raw_temp);
endinterface

interface tmaf_out_if;
  logic                               valid;
  logic                               ready;
  logic [tmaf_pkg::PHASE_W-1:0]       phase;
  logic                               read_request;
  logic                               result_valid;
  logic signed [tmaf_pkg::AVG_W-1:0]  average_centi_c;

  modport source (output valid, output phase, output read_request,
                  output result_valid, output average_centi_c, input ready);
  modport sink   (input valid, input phase, input read_request,
                  input result_valid, input average_centi_c, output ready);
  modport monitor (input valid, input ready, input phase, input read_request,
                   input result_valid, input average_centi_c);
endinterface

[rtl/tmaf_avg_div.sv]
// two-stage divide of the doubled sample sum by the sample count, with offset removal
module tmaf_avg_div #(
  parameter int SAMPLES = tmaf_pkg::SAMPLES_DEF,
  parameter int X_W     = 20
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [X_W-1:0]                    x_i,
  input  logic                              neg_i,
  output logic signed [tmaf_pkg::AVG_W-1:0] avg_o
);

  localparam int K      = X_W;
  localparam int S_W    = $clog2(SAMPLES + 1);
  localparam int CALC_W = X_W + 2;
  localparam logic [K:0] RECIP = (K+1)'((64'd1 << K) / SAMPLES);

  logic [X_W+K:0]     prod;
  logic [X_W-1:0]     q_est_r;
  logic [X_W-1:0]     x_r;
  logic               neg_r;
  logic [X_W+S_W-1:0] qs;
  logic [X_W-1:0]     rem;
  logic               rem_hi;
  logic [X_W-1:0]     rem_fix;
  logic [X_W-1:0]     q_fix;
  logic               ceil_add;
  logic signed [CALC_W-1:0] avg_wide;

  // reciprocal estimate is the true quotient or one below it
  assign prod = (X_W+K+1)'(x_i) * (X_W+K+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_est_r <= prod[K +: X_W];
      x_r     <= x_i;
      neg_r   <= neg_i;
    end
  end

  always_comb begin
    qs       = {{S_W{1'b0}}, q_est_r} * (X_W+S_W)'(SAMPLES);
    rem      = x_r - qs[X_W-1:0];
    rem_hi   = (rem >= X_W'(SAMPLES));
    rem_fix  = rem_hi ? (rem - X_W'(SAMPLES)) : rem;
    q_fix    = q_est_r + X_W'(rem_hi);
    // negative totals truncate towards zero, so round the quotient up
    ceil_add = neg_r && (rem_fix != '0);
    avg_wide = $signed({2'b00, q_fix}) + $signed(CALC_W'(ceil_add))
             - $signed(CALC_W'(tmaf_pkg::OFFSET_CENTI));
    avg_o    = avg_wide[tmaf_pkg::AVG_W-1:0];
  end

endmodule

[rtl/thermometer_measure_average_fsm.sv]
// top level of the thermometer measure and average controller
//
// in_if carries one tick per transfer: a button event and an optional raw
// sensor sample (0.02 K per lsb). out_if returns one result per tick: the
// phase after the tick, a read request, a flag on the tick an average was
// completed and the latest average in hundredths of a degree Celsius.
// The controller steps waiting -> measuring -> displaying -> waiting; a button
// press is held until a waiting or displaying tick uses it.
// Throughput is one tick per cycle while out_if is not stalled; the state update
// and accumulation sit in the first stage, the reciprocal multiply of the
// averaging divide in the second and its remainder correction in the third.
// While out_if is stalled the whole pipeline holds and in_if.ready is low;
// the result register frees as soon as its transfer completes.
// A synchronous reset returns to waiting with no pending press, a zero sum
// and a zero average, and empties the pipeline.
module thermometer_measure_average_fsm #(
  parameter int SAMPLES = tmaf_pkg::SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tmaf_in_if.sink   in_if,
  tmaf_out_if.source out_if
);

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = tmaf_pkg::RAW_W + $clog2(SAMPLES);
  localparam int X_W   = SUM_W + 1;
  localparam logic [X_W:0] OFF_TOTAL = (X_W+1)'(tmaf_pkg::OFFSET_CENTI * SAMPLES);

  tmaf_pkg::state_t state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic             pend;
  logic [CNT_W-1:0] cnt_acc;
  logic [SUM_W-1:0] sum_acc;
  logic             req;
  logic             done;
  logic [X_W-1:0]   x;

  logic en;
  logic in_fire;

  // pipeline stages
  logic                               v1_r, v2_r, out_valid_r;
  tmaf_pkg::state_t                   phase1_r, phase2_r;
  logic                               req1_r, req2_r, done1_r, done2_r;
  logic [X_W-1:0]                     x1_r;
  logic                               neg1_r;
  logic signed [tmaf_pkg::AVG_W-1:0]  avg;
  logic signed [tmaf_pkg::AVG_W-1:0]  last_avg_r, last_avg_nxt;
  logic [tmaf_pkg::PHASE_W-1:0]       out_phase_r;
  logic                               out_req_r, out_done_r;
  logic signed [tmaf_pkg::AVG_W-1:0]  out_avg_r;

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;
  assign in_fire     = in_if.valid && en;

  always_comb begin
    pend      = pend_r | in_if.button_pressed;
    state_nxt = state_r;
    pend_nxt  = pend;
    first_nxt = first_r;
    cnt_acc   = cnt_r;
    sum_acc   = sum_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    req       = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      tmaf_pkg::ST_WAITING: begin
        if (pend) begin
          pend_nxt  = 1'b0;
          state_nxt = tmaf_pkg::ST_MEASURING;
        end
      end
      tmaf_pkg::ST_MEASURING: begin
        if (first_r) begin
          req       = 1'b1;
          first_nxt = 1'b0;
        end
        if (in_if.sample_valid) begin
          sum_acc = sum_r + SUM_W'(in_if.raw_temp);
          cnt_acc = cnt_r + CNT_W'(1);
          if (cnt_acc != CNT_W'(SAMPLES)) begin
            req = 1'b1;
          end
        end
        cnt_nxt = cnt_acc;
        sum_nxt = sum_acc;
        if (cnt_acc == CNT_W'(SAMPLES)) begin
          done      = 1'b1;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = tmaf_pkg::ST_DISPLAY;
        end
      end
      tmaf_pkg::ST_DISPLAY: begin
        if (pend) begin
          pend_nxt  = 1'b0;
          state_nxt = tmaf_pkg::ST_WAITING;
        end
      end
      default: begin
        state_nxt = tmaf_pkg::ST_WAITING;
      end
    endcase
    x = {sum_acc, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmaf_pkg::ST_WAITING;
      pend_r  <= 1'b0;
      first_r <= 1'b1;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      last_avg_r  <= '0;
    end else if (en) begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      last_avg_r  <= last_avg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase1_r    <= state_nxt;
      req1_r      <= req;
      done1_r     <= done;
      x1_r        <= x;
      neg1_r      <= ({1'b0, x} < OFF_TOTAL);
      phase2_r    <= phase1_r;
      req2_r      <= req1_r;
      done2_r     <= done1_r;
      out_phase_r <= phase2_r;
      out_req_r   <= req2_r;
      out_done_r  <= done2_r;
      out_avg_r   <= last_avg_nxt;
    end
  end

  tmaf_avg_div #(
    .SAMPLES (SAMPLES),
    .X_W     (X_W)
  ) u_avg_div (
    .clk   (clk),
    .en    (en),
    .x_i   (x1_r),
    .neg_i (neg1_r),
    .avg_o (avg)
  );

  // average moves on only with a completed measurement in the last stage
  assign last_avg_nxt = (v2_r && done2_r) ? avg : last_avg_r;

  assign out_if.valid           = out_valid_r;
  assign out_if.phase           = out_phase_r;
  assign out_if.read_request    = out_req_r;
  assign out_if.result_valid    = out_done_r;
  assign out_if.average_centi_c = out_avg_r;

endmodule

[rtl/tmaf_checker.sv]
// port-level checks of the thermometer controller, bound to the top level
module tmaf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tmaf_pkg::PHASE_W-1:0]      out_phase,
  input logic                              out_read_request,
  input logic                              out_result_valid,
  input logic signed [tmaf_pkg::AVG_W-1:0] out_average_centi_c
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase)
      && $stable(out_average_centi_c) && $stable(out_result_valid))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a finished average always lands in the display phase
  a_done_display: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_valid |-> out_phase == tmaf_pkg::ST_DISPLAY)
    else $error("average completed outside display phase");

  // a read request without completion keeps the controller measuring
  a_req_measuring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_request && !out_result_valid
      |-> out_phase == tmaf_pkg::ST_MEASURING)
    else $error("read request outside measuring phase");

  // the average only changes on a completion transfer
  a_avg_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && !out_result_valid
      |-> $stable(out_average_centi_c))
    else $error("average changed without completion");

endmodule

bind thermometer_measure_average_fsm tmaf_checker u_tmaf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_phase           (out_if.phase),
  .out_read_request    (out_if.read_request),
  .out_result_valid    (out_if.result_valid),
  .out_average_centi_c (out_if.average_centi_c)
);
